FILE: rtl/unicode_glyph_map_core_macros.svh
`ifndef UNICODE_GLYPH_MAP_CORE_MACROS_SVH
`define UNICODE_GLYPH_MAP_CORE_MACROS_SVH

// property that must hold at every sampled edge
`define UGM_ASSERT_ALWAYS(lbl, clk, cond, msg) \
    lbl: assert property (@(posedge clk) (cond)) else $error(msg);

// implication into the next cycle, checked through reset as well
`define UGM_ASSERT_NEXT(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

// implication into the next cycle, off while reset is held
`define UGM_ASSERT_NEXT_RST(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/ugm_pkg.sv
`default_nettype none

package ugm_pkg;

    localparam int MAP_SIZE_DEF    = 65536;
    localparam int CMD_Q_DEPTH_DEF = 4;
    localparam int RES_Q_DEPTH_DEF = 2;

    localparam int CP_W    = 21;
    localparam int GLYPH_W = 16;
    localparam int GC_W    = 17;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_TABLE  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    localparam logic [7:0] BYTE_GLYPH_END = 8'hFF;
    localparam logic [7:0] BYTE_SEP       = 8'hFE;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_PLANE1      = 21'h010000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_BIND   = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CP_W-1:0]    cp;
        logic [GLYPH_W-1:0] glyph;
    } t_cmd;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               from_map;
    } t_res;

    typedef struct packed {
        logic            unicode_en;
        logic [GC_W-1:0] glyph_count;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/unicode_glyph_map_core.sv
`default_nettype none

// Codepoint-to-glyph map built from a font's unicode table. The front takes
// one item per cycle while full is low, runs the utf-8 decoder and pushes to
// a command queue; a byte that yields two codepoints (bad continuation followed
// by a storable lead byte) holds full high until the second one is pushed. The
// back owns the map memory with its single read and single write port: each
// bind and lookup is read in S_IDLE and checked in S_CHECK, where a bind writes
// an empty entry, before the next command is taken. A clear action sweeps the
// whole map in S_SWEEP while the queue keeps filling. After reset the back runs
// a clearing pass over the map during which full stays high. Lookup results
// wait in a result queue of RES_Q_DEPTH entries (two by default), which they
// enter from S_CHECK after passing the command queue and the map read in S_IDLE.
module unicode_glyph_map_core #(
    parameter int MAP_SIZE    = ugm_pkg::MAP_SIZE_DEF,
    parameter int CMD_Q_DEPTH = ugm_pkg::CMD_Q_DEPTH_DEF,
    parameter int RES_Q_DEPTH = ugm_pkg::RES_Q_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [1:0]                   i_action,
    input  wire logic [7:0]                   i_table_byte,
    input  wire logic                         i_last_byte,
    input  wire logic [ugm_pkg::CP_W-1:0]     i_codepoint,
    output logic                              empty,
    input  wire logic                         pop,
    output logic      [ugm_pkg::GLYPH_W-1:0]  o_glyph,
    output logic                              o_from_map,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    import ugm_pkg::*;

    logic            r_unicode_en;
    logic [GC_W-1:0] r_glyph_count;
    t_cfg            cfg;

    logic cmd_push, cmd_pop, cmd_full, cmd_empty;
    t_cmd cmd_in, cmd_out;
    logic res_push, res_full;
    t_res res_in, res_out;
    logic init_busy;

    assign pready = 1'b1;
    assign cfg.unicode_en  = r_unicode_en;
    assign cfg.glyph_count = r_glyph_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unicode_en  <= 1'b0;
            r_glyph_count <= GC_W'(256);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_glyph_count <= pwdata[GC_W-1:0];
            end else begin
                r_unicode_en <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2]) begin
            prdata = 32'(r_glyph_count);
        end else begin
            prdata = 32'(r_unicode_en);
        end
    end

    ugm_front #(
        .MAP_SIZE (MAP_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_table_byte (i_table_byte),
        .i_last_byte  (i_last_byte),
        .i_codepoint  (i_codepoint),
        .i_init_busy  (init_busy),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    ugm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    ugm_back #(
        .MAP_SIZE (MAP_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_init_busy (init_busy)
    );

    ugm_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_glyph    = res_out.glyph;
    assign o_from_map = res_out.from_map;

endmodule

`default_nettype wire

FILE: rtl/ugm_ram.sv
`default_nettype none

module ugm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/ugm_fifo.sv
`default_nettype none

module ugm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ugm_front.sv
`default_nettype none

module ugm_front #(
    parameter int MAP_SIZE = ugm_pkg::MAP_SIZE_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ugm_pkg::t_cfg             i_cfg,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic [1:0]                i_action,
    input  wire logic [7:0]                i_table_byte,
    input  wire logic                      i_last_byte,
    input  wire logic [ugm_pkg::CP_W-1:0]  i_codepoint,
    input  wire logic                      i_init_busy,
    input  wire logic                      i_cmd_full,
    output logic                           o_cmd_push,
    output ugm_pkg::t_cmd                  o_cmd
);

    import ugm_pkg::*;

    logic [GC_W-1:0]    r_cur, n_cur;
    logic [CP_W-1:0]    r_part, n_part;
    logic [1:0]         r_pend, n_pend;
    logic               r_xv, n_xv;
    logic [CP_W-1:0]    r_xcp, n_xcp;
    logic [GLYPH_W-1:0] r_xglyph, n_xglyph;

    logic [GC_W-1:0]    d_cur;
    logic [CP_W-1:0]    d_part;
    logic [1:0]         d_pend;
    logic [CP_W-1:0]    part_acc;
    logic               cont_v, lead_v, lead_en;
    logic [CP_W-1:0]    cont_cp, lead_cp;
    logic               s0_v, s1_v;
    logic [CP_W-1:0]    s0_cp, s1_cp;
    logic               dec_en, accept;

    assign o_full   = r_xv || i_cmd_full || i_init_busy;
    assign accept   = i_push && !o_full;
    assign dec_en   = i_cfg.unicode_en && (r_cur < i_cfg.glyph_count);
    assign part_acc = {r_part[CP_W-7:0], i_table_byte[5:0]};

    // utf-8 decode of one table byte
    always_comb begin
        d_cur   = r_cur;
        d_part  = r_part;
        d_pend  = r_pend;
        cont_v  = 1'b0;
        cont_cp = CP_REPLACEMENT;
        lead_en = 1'b1;
        lead_v  = 1'b0;
        lead_cp = CP_REPLACEMENT;
        if (r_pend != 2'd0) begin
            if (i_table_byte[7:6] == 2'b10) begin
                lead_en = 1'b0;
                d_pend  = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    cont_v  = 1'b1;
                    cont_cp = part_acc;
                    d_part  = '0;
                end else begin
                    d_part = part_acc;
                end
            end else begin
                cont_v = 1'b1;
                d_pend = 2'd0;
                d_part = '0;
            end
        end
        if (lead_en) begin
            if (i_table_byte == BYTE_GLYPH_END) begin
                d_cur = r_cur + GC_W'(1);
            end else if (i_table_byte == BYTE_SEP) begin
                d_cur = r_cur;
            end else if (!i_table_byte[7]) begin
                lead_v  = 1'b1;
                lead_cp = CP_W'(i_table_byte);
            end else if (i_table_byte[7:5] == 3'b110) begin
                d_part = CP_W'(i_table_byte[4:0]);
                d_pend = 2'd1;
            end else if (i_table_byte[7:4] == 4'b1110) begin
                d_part = CP_W'(i_table_byte[3:0]);
                d_pend = 2'd2;
            end else if (i_table_byte[7:3] == 5'b11110) begin
                d_part = CP_W'(i_table_byte[2:0]);
                d_pend = 2'd3;
            end else begin
                lead_v = 1'b1;
            end
        end
        cont_v = cont_v && (cont_cp < CP_W'(MAP_SIZE));
        lead_v = lead_v && (lead_cp < CP_W'(MAP_SIZE));
        if (cont_v) begin
            s0_v  = 1'b1;
            s0_cp = cont_cp;
            s1_v  = lead_v;
            s1_cp = lead_cp;
        end else begin
            s0_v  = lead_v;
            s0_cp = lead_cp;
            s1_v  = 1'b0;
            s1_cp = lead_cp;
        end
    end

    always_comb begin
        n_cur      = r_cur;
        n_part     = r_part;
        n_pend     = r_pend;
        n_xv       = r_xv;
        n_xcp      = r_xcp;
        n_xglyph   = r_xglyph;
        o_cmd_push = 1'b0;
        o_cmd.op    = OP_BIND;
        o_cmd.cp    = s0_cp;
        o_cmd.glyph = r_cur[GLYPH_W-1:0];
        if (r_xv) begin
            o_cmd.cp    = r_xcp;
            o_cmd.glyph = r_xglyph;
            if (!i_cmd_full) begin
                o_cmd_push = 1'b1;
                n_xv       = 1'b0;
            end
        end else if (accept) begin
            case (i_action)
                ACT_CLEAR: begin
                    o_cmd_push = 1'b1;
                    o_cmd.op   = OP_CLEAR;
                    n_cur      = '0;
                    n_part     = '0;
                    n_pend     = 2'd0;
                end
                ACT_TABLE: begin
                    if (dec_en) begin
                        n_cur      = d_cur;
                        n_part     = d_part;
                        n_pend     = d_pend;
                        o_cmd_push = s0_v;
                        n_xv       = s1_v;
                        n_xcp      = s1_cp;
                        n_xglyph   = r_cur[GLYPH_W-1:0];
                    end
                    if (i_last_byte) begin
                        n_part = '0;
                        n_pend = 2'd0;
                    end
                end
                ACT_LOOKUP: begin
                    o_cmd_push = 1'b1;
                    o_cmd.op   = OP_LOOKUP;
                    o_cmd.cp   = i_codepoint;
                end
                default: begin
                    o_cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_part <= '0;
            r_pend <= 2'd0;
            r_xv   <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_part <= n_part;
            r_pend <= n_pend;
            r_xv   <= n_xv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xcp    <= n_xcp;
        r_xglyph <= n_xglyph;
    end

endmodule

`default_nettype wire

FILE: rtl/ugm_back.sv
`default_nettype none

module ugm_back #(
    parameter int MAP_SIZE = ugm_pkg::MAP_SIZE_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ugm_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_empty,
    input  wire ugm_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output ugm_pkg::t_res      o_res,
    output logic               o_init_busy
);

    import ugm_pkg::*;

    localparam int AW = $clog2(MAP_SIZE);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_SWEEP = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_init, n_init;
    t_cmd            r_cmd, n_cmd;
    logic            r_in_map, n_in_map;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [GLYPH_W-1:0] ram_wdata, ram_rdata;
    logic               hit;

    ugm_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (MAP_SIZE)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_init_busy = r_init;
    assign hit = i_cfg.unicode_en && r_in_map && ((ram_rdata != '0) || (r_cmd.cp == '0));

    // lookup answer
    always_comb begin
        o_res.glyph    = '0;
        o_res.from_map = 1'b0;
        if (hit) begin
            o_res.glyph    = ram_rdata;
            o_res.from_map = 1'b1;
        end else if (!(i_cfg.unicode_en && !r_in_map) &&
                     (r_cmd.cp < CP_W'(i_cfg.glyph_count)) && (r_cmd.cp < CP_PLANE1)) begin
            o_res.glyph = r_cmd.cp[GLYPH_W-1:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_init     = r_init;
        n_cmd      = r_cmd;
        n_in_map   = r_in_map;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = i_cmd.cp[AW-1:0];
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_SWEEP: begin
                ram_we = 1'b1;
                if (r_addr == AW'(MAP_SIZE - 1)) begin
                    n_state = S_IDLE;
                    n_init  = 1'b0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_in_map  = (i_cmd.cp < CP_W'(MAP_SIZE));
                    if (i_cmd.op == OP_CLEAR) begin
                        n_state = S_SWEEP;
                        n_addr  = '0;
                    end else begin
                        ram_re  = 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                ram_waddr = r_cmd.cp[AW-1:0];
                ram_wdata = r_cmd.glyph;
                if (r_cmd.op == OP_BIND) begin
                    ram_we = r_in_map && (ram_rdata == '0);
                end
                o_res_push = (r_cmd.op == OP_LOOKUP);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_addr  <= '0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_init  <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_in_map <= n_in_map;
    end

endmodule

`default_nettype wire

FILE: rtl/ugm_checker.sv
`default_nettype none

`include "unicode_glyph_map_core_macros.svh"

module ugm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        full,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic [ugm_pkg::GLYPH_W-1:0] o_glyph,
    input wire logic                        o_from_map,
    input wire logic                        pready
);

    // map clearing pass follows every reset
    `UGM_ASSERT_NEXT(a_full_after_reset, i_clk, !i_rst_n, full, "input open during map clear")
    `UGM_ASSERT_NEXT(a_empty_after_reset, i_clk, !i_rst_n, empty, "result left over reset")
    `UGM_ASSERT_NEXT_RST(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_glyph) && $stable(o_from_map), "waiting result changed")
    `UGM_ASSERT_ALWAYS(a_pready_high, i_clk, pready, "config port not ready")

endmodule

bind unicode_glyph_map_core ugm_checker u_ugm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_glyph    (o_glyph),
    .o_from_map (o_from_map),
    .pready     (pready)
);

`default_nettype wire
